FILE: sv/dwsp_pkg.sv
package dwsp_pkg;

  localparam int DVD_W = 52;
  localparam int DVS_W = 40;
  localparam int DIV_CNT_W = 6;
  localparam logic [29:0] DEN_K = 30'd823550000;
  localparam logic [3:0] REG_PROP = 4'd0;
  localparam logic [3:0] REG_INTEG = 4'd1;
  localparam logic [3:0] REG_DERIV = 4'd2;
  localparam logic [3:0] REG_PERIOD = 4'd3;
  localparam logic [3:0] REG_LIMIT = 4'd4;
  localparam logic [3:0] REG_TRACK = 4'd5;
  localparam logic [3:0] REG_RADIUS = 4'd6;
  localparam logic [3:0] REG_CPR = 4'd7;

  typedef enum logic [4:0] {
    ST_IDLE, ST_NUM, ST_RPM_GO, ST_RPM_WAIT, ST_FF_MUL, ST_FF_SHIFT, ST_ERR,
    ST_DER_GO, ST_DER_WAIT, ST_ES, ST_MUL_P, ST_MUL_I, ST_MUL_D, ST_CORR,
    ST_DRIVE, ST_MR_GO, ST_MR_WAIT, ST_ML_GO, ST_ML_WAIT, ST_PUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_NUM, OP_RPM, OP_FF_MUL, OP_FF, OP_ERR, OP_DER, OP_ES, OP_MUL_P,
    OP_MUL_I, OP_MUL_D, OP_CORR, OP_DRIVE, OP_MR, OP_ML
  } op_t;

  typedef struct packed {
    op_t  op;
    logic start;
    logic load;
    logic push;
    logic wheel;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

FILE: sv/dwsp_div.sv
module dwsp_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [dwsp_pkg::DVD_W-1:0]      dividend,
  input  logic        [dwsp_pkg::DVS_W-1:0]      divisor,
  output logic signed [dwsp_pkg::DVD_W-1:0]      quot,
  output logic                                   done
);

  logic [dwsp_pkg::DVD_W-1:0]     a_r, a_nxt;
  logic [dwsp_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [dwsp_pkg::DVS_W-1:0]     d_r, d_nxt;
  logic                           neg_r, neg_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [dwsp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [dwsp_pkg::DVS_W:0]       rem_sh;
  logic                           fits;

  always_comb begin
    rem_sh = {rem_r, a_r[dwsp_pkg::DVD_W-1]};
    fits = rem_sh >= {1'b0, d_r};
    a_nxt = a_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = dividend[dwsp_pkg::DVD_W-1] ? 52'(-dividend) : dividend;
      rem_nxt = '0;
      d_nxt = divisor;
      neg_nxt = dividend[dwsp_pkg::DVD_W-1];
      busy_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (busy_r) begin
      a_nxt = {a_r[dwsp_pkg::DVD_W-2:0], fits};
      rem_nxt = fits ? dwsp_pkg::DVS_W'(rem_sh - {1'b0, d_r})
                     : rem_sh[dwsp_pkg::DVS_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == dwsp_pkg::DIV_CNT_W'(dwsp_pkg::DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quot = neg_r ? $signed(52'(-a_r)) : $signed(a_r);
  assign done = done_r;

endmodule

FILE: sv/dwsp_ctrl.sv
module dwsp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dwsp_pkg::stat_t stat,
  output dwsp_pkg::cmd_t  cmd
);

  dwsp_pkg::state_t state_r, state_nxt;
  logic             wheel_r, wheel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dwsp_pkg::ST_IDLE;
      wheel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wheel_nxt = wheel_r;
    in_tready = 1'b0;
    cmd.op = dwsp_pkg::OP_NONE;
    cmd.start = 1'b0;
    cmd.load = 1'b0;
    cmd.push = 1'b0;
    cmd.wheel = wheel_r;
    unique case (state_r)
      dwsp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          wheel_nxt = 1'b0;
          state_nxt = dwsp_pkg::ST_NUM;
        end
      end
      dwsp_pkg::ST_NUM: begin
        cmd.op = dwsp_pkg::OP_NUM;
        state_nxt = dwsp_pkg::ST_RPM_GO;
      end
      dwsp_pkg::ST_RPM_GO: begin
        cmd.op = dwsp_pkg::OP_RPM;
        cmd.start = 1'b1;
        state_nxt = dwsp_pkg::ST_RPM_WAIT;
      end
      dwsp_pkg::ST_RPM_WAIT: begin
        cmd.op = dwsp_pkg::OP_RPM;
        if (stat.div_done) state_nxt = dwsp_pkg::ST_FF_MUL;
      end
      dwsp_pkg::ST_FF_MUL: begin
        cmd.op = dwsp_pkg::OP_FF_MUL;
        state_nxt = dwsp_pkg::ST_FF_SHIFT;
      end
      dwsp_pkg::ST_FF_SHIFT: begin
        cmd.op = dwsp_pkg::OP_FF;
        state_nxt = dwsp_pkg::ST_ERR;
      end
      dwsp_pkg::ST_ERR: begin
        cmd.op = dwsp_pkg::OP_ERR;
        state_nxt = dwsp_pkg::ST_DER_GO;
      end
      dwsp_pkg::ST_DER_GO: begin
        cmd.op = dwsp_pkg::OP_DER;
        cmd.start = 1'b1;
        state_nxt = dwsp_pkg::ST_DER_WAIT;
      end
      dwsp_pkg::ST_DER_WAIT: begin
        cmd.op = dwsp_pkg::OP_DER;
        if (stat.div_done) state_nxt = dwsp_pkg::ST_ES;
      end
      dwsp_pkg::ST_ES: begin
        cmd.op = dwsp_pkg::OP_ES;
        state_nxt = dwsp_pkg::ST_MUL_P;
      end
      dwsp_pkg::ST_MUL_P: begin
        cmd.op = dwsp_pkg::OP_MUL_P;
        state_nxt = dwsp_pkg::ST_MUL_I;
      end
      dwsp_pkg::ST_MUL_I: begin
        cmd.op = dwsp_pkg::OP_MUL_I;
        state_nxt = dwsp_pkg::ST_MUL_D;
      end
      dwsp_pkg::ST_MUL_D: begin
        cmd.op = dwsp_pkg::OP_MUL_D;
        state_nxt = dwsp_pkg::ST_CORR;
      end
      dwsp_pkg::ST_CORR: begin
        cmd.op = dwsp_pkg::OP_CORR;
        state_nxt = dwsp_pkg::ST_DRIVE;
      end
      dwsp_pkg::ST_DRIVE: begin
        cmd.op = dwsp_pkg::OP_DRIVE;
        if (!wheel_r) begin
          wheel_nxt = 1'b1;
          state_nxt = dwsp_pkg::ST_NUM;
        end else begin
          state_nxt = dwsp_pkg::ST_MR_GO;
        end
      end
      dwsp_pkg::ST_MR_GO: begin
        cmd.op = dwsp_pkg::OP_MR;
        cmd.start = 1'b1;
        state_nxt = dwsp_pkg::ST_MR_WAIT;
      end
      dwsp_pkg::ST_MR_WAIT: begin
        cmd.op = dwsp_pkg::OP_MR;
        if (stat.div_done) state_nxt = dwsp_pkg::ST_ML_GO;
      end
      dwsp_pkg::ST_ML_GO: begin
        cmd.op = dwsp_pkg::OP_ML;
        cmd.start = 1'b1;
        state_nxt = dwsp_pkg::ST_ML_WAIT;
      end
      dwsp_pkg::ST_ML_WAIT: begin
        cmd.op = dwsp_pkg::OP_ML;
        if (stat.div_done) state_nxt = dwsp_pkg::ST_PUSH;
      end
      dwsp_pkg::ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push = 1'b1;
          state_nxt = dwsp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dwsp_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: sv/dwsp_dp.sv
module dwsp_dp #(
  parameter int unsigned MAX_RPM = 105
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [63:0]    in_tdata,
  input  logic           cfg_valid,
  input  logic [3:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  output logic [23:0]    out_tdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  dwsp_pkg::cmd_t cmd,
  output dwsp_pkg::stat_t stat
);

  // divide by MAX_RPM as multiply by a rounded-up reciprocal and shift
  localparam int FF_SH = 31 + $clog2(MAX_RPM);
  localparam logic [31:0] FF_M =
    32'(((64'd1 << FF_SH) + 64'(MAX_RPM) - 64'd1) / 64'(MAX_RPM));

  logic [15:0] kp_r, ki_r, kd_r, cpr_r;
  logic [9:0]  per_r, rad_r;
  logic [7:0]  lim_r;
  logic [11:0] tw_r;

  logic signed [15:0] lin_r, ang_r, cr_r, cl_r;
  logic signed [29:0] n_r;
  logic        [39:0] den_r;
  logic signed [23:0] rpm_r;
  logic        [62:0] ffp_r;
  logic signed [31:0] ff_r;
  logic signed [15:0] err_r;
  logic signed [16:0] der_r;
  logic signed [32:0] pp_r;
  logic signed [48:0] pi_r;
  logic signed [33:0] pd_r;
  logic signed [41:0] corr_r;
  logic signed [15:0] meas_r [2];
  logic signed [31:0] es_r [2];
  logic signed [15:0] last_r [2];
  logic [7:0]  pwm_r [2];
  logic        dir_r [2];
  logic [23:0] odata_r;
  logic        ovalid_r;

  logic [9:0]  per_nz;
  logic [15:0] cpr_nz;
  logic [9:0]  rad_nz;
  logic signed [28:0] turn;
  logic signed [29:0] lin2k;
  logic signed [51:0] n_ext, dvd;
  logic        [39:0] dvs;
  logic signed [51:0] quot;
  logic               div_done;
  logic        [23:0] rpm_abs;
  logic        [30:0] ff_x;
  logic        [31:0] ff_q;
  logic signed [24:0] err_diff;
  logic signed [26:0] err_per;
  logic signed [32:0] es_sum;
  logic signed [49:0] pid_sum, pid_adj;
  logic signed [42:0] drive;
  logic        [42:0] mag;
  logic signed [15:0] q_sat;
  logic               w;

  assign w = cmd.wheel;
  assign per_nz = (per_r == '0) ? 10'd1 : per_r;
  assign cpr_nz = (cpr_r == '0) ? 16'd1 : cpr_r;
  assign rad_nz = (rad_r == '0) ? 10'd1 : rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= 16'd256;
      ki_r <= '0;
      kd_r <= '0;
      per_r <= 10'd10;
      lim_r <= 8'd100;
      tw_r <= 12'd300;
      rad_r <= 10'd50;
      cpr_r <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dwsp_pkg::REG_PROP:   kp_r <= cfg_data;
        dwsp_pkg::REG_INTEG:  ki_r <= cfg_data;
        dwsp_pkg::REG_DERIV:  kd_r <= cfg_data;
        dwsp_pkg::REG_PERIOD: per_r <= cfg_data[9:0];
        dwsp_pkg::REG_LIMIT:  lim_r <= cfg_data[7:0];
        dwsp_pkg::REG_TRACK:  tw_r <= cfg_data[11:0];
        dwsp_pkg::REG_RADIUS: rad_r <= cfg_data[9:0];
        dwsp_pkg::REG_CPR:    cpr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    turn = 29'(ang_r * $signed({1'b0, tw_r}));
    lin2k = 30'(lin_r * 30'sd2000);
    n_ext = 52'(n_r);
    dvd = '0;
    dvs = 40'd1;
    case (cmd.op)
      dwsp_pkg::OP_RPM: begin
        dvd = (n_ext <<< 22) - (n_ext <<< 18);
        dvs = den_r;
      end
      dwsp_pkg::OP_DER: begin
        dvd = 52'(17'(err_r) - 17'(last_r[w]));
        dvs = 40'(per_nz);
      end
      dwsp_pkg::OP_MR: begin
        dvd = 52'(52'(cr_r) * 52'sd6000);
        dvs = 40'(cpr_nz);
      end
      dwsp_pkg::OP_ML: begin
        dvd = 52'(52'(cl_r) * 52'sd6000);
        dvs = 40'(cpr_nz);
      end
      default: ;
    endcase
  end

  dwsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .done     (div_done)
  );

  always_comb begin
    if (quot > 52'sd32767) q_sat = 16'sh7fff;
    else if (quot < -52'sd32768) q_sat = -16'sh8000;
    else q_sat = quot[15:0];

    rpm_abs = rpm_r[23] ? 24'(-rpm_r) : rpm_r;
    ff_x = (31'(rpm_abs) << 8) - 31'(rpm_abs);
    ff_q = 32'(ffp_r >> FF_SH);

    err_diff = 25'(rpm_r) - 25'(meas_r[w]);
    err_per = 27'(err_r * $signed({1'b0, per_nz}));
    es_sum = 33'(es_r[w]) + 33'(err_per);
    pid_sum = 50'(pp_r) + 50'(pi_r) + 50'(pd_r);
    pid_adj = pid_sum[49] ? pid_sum + 50'sd255 : pid_sum;
    if (corr_r > $signed({34'd0, lim_r})) drive = 43'(ff_r);
    else drive = 43'(ff_r) + 43'(corr_r);
    mag = drive[42] ? 43'(-drive) : drive;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lin_r <= in_tdata[15:0];
      ang_r <= in_tdata[31:16];
      cr_r <= in_tdata[47:32];
      cl_r <= in_tdata[63:48];
    end
    case (cmd.op)
      dwsp_pkg::OP_NUM: begin
        n_r <= w ? lin2k - 30'(turn) : lin2k + 30'(turn);
        den_r <= 40'(rad_nz * dwsp_pkg::DEN_K);
      end
      dwsp_pkg::OP_FF_MUL: ffp_r <= {32'd0, ff_x} * {31'd0, FF_M};
      dwsp_pkg::OP_FF: ff_r <= rpm_r[23] ? 32'(-ff_q) : ff_q;
      dwsp_pkg::OP_ERR: begin
        if (err_diff > 25'sd32767) err_r <= 16'sh7fff;
        else if (err_diff < -25'sd32768) err_r <= -16'sh8000;
        else err_r <= err_diff[15:0];
      end
      dwsp_pkg::OP_MUL_P: pp_r <= 33'(33'(err_r) * $signed({17'd0, kp_r}));
      dwsp_pkg::OP_MUL_I: pi_r <= 49'(49'(es_r[w]) * $signed({33'd0, ki_r}));
      dwsp_pkg::OP_MUL_D: pd_r <= 34'(34'(der_r) * $signed({18'd0, kd_r}));
      dwsp_pkg::OP_CORR: corr_r <= 42'(pid_adj >>> 8);
      default: ;
    endcase
    if (div_done) begin
      case (cmd.op)
        dwsp_pkg::OP_RPM: rpm_r <= quot[23:0];
        dwsp_pkg::OP_DER: der_r <= quot[16:0];
        default: ;
      endcase
    end
    if (cmd.op == dwsp_pkg::OP_DRIVE) begin
      dir_r[w] <= !drive[42];
      pwm_r[w] <= (mag > 43'd255) ? 8'hff : mag[7:0];
    end
    if (cmd.push) odata_r <= {6'd0, dir_r[1], pwm_r[1], dir_r[0], pwm_r[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_r <= '{default: '0};
      es_r <= '{default: '0};
      last_r <= '{default: '0};
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.op == dwsp_pkg::OP_ES) begin
        if (es_sum > 33'sh0_7fff_ffff) es_r[w] <= 32'sh7fff_ffff;
        else if (es_sum < -33'sh0_8000_0000) es_r[w] <= -32'sh8000_0000;
        else es_r[w] <= es_sum[31:0];
        last_r[w] <= err_r;
      end
      if (div_done && cmd.op == dwsp_pkg::OP_MR) meas_r[0] <= q_sat;
      if (div_done && cmd.op == dwsp_pkg::OP_ML) meas_r[1] <= q_sat;
      if (cmd.push) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  assign out_tdata = odata_r;
  assign out_tvalid = ovalid_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !ovalid_r || out_tready;

endmodule

FILE: sv/diff_drive_wheel_speed_pid_top.sv
// Items are handled one at a time, each using the shared 52-step radix-2 divider,
//   run six times per item (target RPM, derivative and measured RPM, for each
//   wheel); a result held by out_tready low stalls the next item.
// Reset (rst_n low, synchronous): registers take their defaults, PID state and
//   measured RPM clear to zero, no result pending.
module diff_drive_wheel_speed_pid_top #(
  parameter int unsigned MAX_RPM = 105
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // linear_mm_s, angular_mrad_s, count_right, count_left
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pwm_right, dir_right, pwm_left, dir_left, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dwsp_pkg::cmd_t  cmd;
  dwsp_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  dwsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dwsp_dp #(
    .MAX_RPM (MAX_RPM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam longint MAX_RPM_VAL = 105;
  localparam longint TWO_PI_Q16 = 411775;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    bit [7:0] pwm_r;
    bit       dir_r;
    bit [7:0] pwm_l;
    bit       dir_l;
  } wheel_cmd_t;

  class wheel_scoreboard;
    longint kp, ki, kd, period, limit, track, radius, cpr;
    longint meas_rpm[2];
    longint err_sum[2];
    longint prev_err[2];
    wheel_cmd_t pending_q[$];
    int errors;

    function new();
      kp = 256; ki = 0; kd = 0; period = 10; limit = 100;
      track = 300; radius = 50; cpr = 1000;
      for (int i = 0; i < 2; i++) begin
        meas_rpm[i] = 0; err_sum[i] = 0; prev_err[i] = 0;
      end
      errors = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void set_reg(bit [3:0] idx, bit [15:0] v);
      case (idx)
        dwsp_pkg::REG_PROP:   kp = v;
        dwsp_pkg::REG_INTEG:  ki = v;
        dwsp_pkg::REG_DERIV:  kd = v;
        dwsp_pkg::REG_PERIOD: period = v[9:0];
        dwsp_pkg::REG_LIMIT:  limit = v[7:0];
        dwsp_pkg::REG_TRACK:  track = v[11:0];
        dwsp_pkg::REG_RADIUS: radius = v[9:0];
        dwsp_pkg::REG_CPR:    cpr = v;
        default: ;
      endcase
    endfunction

    function longint wheel_drive(int w, longint n);
      longint den, rpm, ff, per, err, der, corr;
      den = 2000 * (radius == 0 ? 1 : radius) * TWO_PI_Q16;
      rpm = (n * 60 * 65536) / den;
      ff = (rpm * 255) / MAX_RPM_VAL;
      per = period == 0 ? 1 : period;
      err = clamp(rpm - meas_rpm[w], -32768, 32767);
      err_sum[w] = clamp(err_sum[w] + err * per, -64'sh8000_0000, 64'sh7FFF_FFFF);
      der = (err - prev_err[w]) / per;
      prev_err[w] = err;
      corr = (err * kp + err_sum[w] * ki + der * kd) / 256;
      return corr > limit ? ff : ff + corr;
    endfunction

    function void to_pwm(longint drive, output bit [7:0] pwm, output bit dir);
      longint mag;
      mag = drive < 0 ? -drive : drive;
      dir = drive >= 0;
      pwm = mag > 255 ? 8'd255 : mag[7:0];
    endfunction

    function void note_command(longint lin, longint ang, longint cr, longint cl);
      longint turn, dr, dl, c;
      wheel_cmd_t e;
      turn = ang * track;
      dr = wheel_drive(0, 2000 * lin + turn);
      dl = wheel_drive(1, 2000 * lin - turn);
      to_pwm(dr, e.pwm_r, e.dir_r);
      to_pwm(dl, e.pwm_l, e.dir_l);
      pending_q.push_back(e);
      c = cpr == 0 ? 1 : cpr;
      meas_rpm[0] = clamp((cr * 6000) / c, -32768, 32767);
      meas_rpm[1] = clamp((cl * 6000) / c, -32768, 32767);
    endfunction

    function void check_drive(bit [23:0] d);
      wheel_cmd_t e;
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, d);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (d[7:0] !== e.pwm_r) begin
        $display("%0t pwm_right: expected %0d actual %0d", $time, e.pwm_r, d[7:0]);
        errors++;
      end
      if (d[8] !== e.dir_r) begin
        $display("%0t dir_right: expected %0d actual %0d", $time, e.dir_r, d[8]);
        errors++;
      end
      if (d[16:9] !== e.pwm_l) begin
        $display("%0t pwm_left: expected %0d actual %0d", $time, e.pwm_l, d[16:9]);
        errors++;
      end
      if (d[17] !== e.dir_l) begin
        $display("%0t dir_left: expected %0d actual %0d", $time, e.dir_l, d[17]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;

  wheel_scoreboard sb;
  bit quiet;
  int out_stall;
  int idle_cycles;

  diff_drive_wheel_speed_pid_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall <= out_stall - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      out_stall <= $urandom_range(0, 6);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_drive(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_cmd(shortint lin, shortint ang, shortint cr, shortint cl);
    in_tdata <= {cl, cr, ang, lin};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_command(lin, ang, cr, cl);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic write_reg(bit [3:0] idx, bit [15:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(bit [15:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
    write_reg(4'($urandom_range(8, 15)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic shortint pick16(bit narrow, int span);
    if (narrow) return shortint'($urandom_range(0, 2 * span) - span);
    return shortint'($urandom);
  endfunction

  initial begin
    bit [15:0] regs [8];
    bit narrow;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    out_stall = 0;
    idle_cycles = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(0, 0, 0, 0);
    send_cmd(32767, 0, 0, 0);
    send_cmd(-32768, 0, 0, 0);
    send_cmd(0, 32767, 32767, -32768);
    send_cmd(0, -32768, -32768, 32767);
    send_cmd(500, 0, 80, 80);
    send_cmd(-500, 1000, -50, 60);
    send_cmd(100, 200, 10, 10);
    send_cmd(-1, -1, -1, -1);
    drain();

    regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
             16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
    write_all(regs);
    send_cmd(32767, 32767, 32767, 32767);
    send_cmd(-32768, -32768, -32768, -32768);
    send_cmd(0, 0, 1, -1);
    send_cmd(32767, -32768, 0, 0);
    send_cmd(1, 1, 0, 0);
    drain();

    regs = '{16'd256, 16'd16, 16'd64, 16'd1, 16'd255, 16'd300, 16'd50, 16'd1000};
    write_all(regs);
    send_cmd(300, 0, 400, 400);
    send_cmd(300, 0, 400, 400);
    send_cmd(-300, 0, -400, -400);
    send_cmd(200, 500, 300, 100);
    send_cmd(0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) regs = '{16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 16'd1, 16'd1, 16'd1};
      else if (ph == 1) regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000, 16'd255,
                                 16'd4095, 16'd1023, 16'hFFFF};
      else begin
        regs[0] = $urandom_range(0, 1) ? 16'($urandom_range(0, 1024)) : 16'($urandom);
        regs[1] = $urandom_range(0, 1) ? 16'($urandom_range(0, 64)) : 16'($urandom);
        regs[2] = $urandom_range(0, 1) ? 16'($urandom_range(0, 512)) : 16'($urandom);
        regs[3] = 16'($urandom);
        regs[4] = 16'($urandom);
        regs[5] = $urandom_range(0, 1) ? 16'($urandom_range(100, 600)) : 16'($urandom);
        regs[6] = $urandom_range(0, 1) ? 16'($urandom_range(20, 100)) : 16'($urandom);
        regs[7] = $urandom_range(0, 1) ? 16'($urandom_range(200, 4000)) : 16'($urandom);
      end
      write_all(regs);
      if (ph == 7) quiet = 1'b1;
      for (int k = 0; k < 100; k++) begin
        narrow = $urandom_range(0, 3) != 0;
        send_cmd(pick16(narrow, 600), pick16(narrow, 2000),
                 pick16(narrow, 300), pick16(narrow, 300));
      end
      drain();
    end

    if (sb.pending_q.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
